[hw/rtl/beam_block_copy_pair_builder_assert.svh]
// ----------------------------------------------------------------------------
// beam block copy pair builder assertion macros
// concurrent checks clocked on clk_i, disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef BEAM_BLOCK_COPY_PAIR_BUILDER_ASSERT_SVH
`define BEAM_BLOCK_COPY_PAIR_BUILDER_ASSERT_SVH

// same-cycle implication
`define BBCP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BBCP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/bbcp_pkg.sv]
// ----------------------------------------------------------------------------
// bbcp_pkg
// shared widths, codes and controller/datapath types of the copy pair builder
// ----------------------------------------------------------------------------
package bbcp_pkg;

  localparam int ID_W     = 17;
  localparam int BEAM_W   = 3;
  localparam int COL_W    = 4;
  localparam int PAR_W    = 9;
  localparam int LEN_W    = 20;
  localparam int BC_W     = 4;
  localparam int BPB_W    = 5;
  localparam int TPB_W    = 16;
  localparam int CNT_W    = 5;
  localparam int ACC_W    = 21;
  localparam int CFG_AW   = 2;
  localparam int CFG_DW   = 16;
  localparam int S_DATA_W = 56;
  localparam int M_DATA_W = 40;

  // input tdata layout
  localparam int S_BEAM_LSB = 0;
  localparam int S_COL_LSB  = S_BEAM_LSB + BEAM_W;
  localparam int S_ID_LSB   = S_COL_LSB + COL_W;
  localparam int S_PAR_LSB  = S_ID_LSB + ID_W;
  localparam int S_LEN_LSB  = S_PAR_LSB + PAR_W;

  // output tdata layout
  localparam int M_SRC_LSB = 0;
  localparam int M_DST_LSB = M_SRC_LSB + ID_W;
  localparam int M_COL_LSB = M_DST_LSB + ID_W;

  localparam logic [ID_W-1:0] NO_BLOCK = '1;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_BUILD = 1'b1;

  localparam logic STAT_OK        = 1'b0;
  localparam logic STAT_BAD_BEAM  = 1'b1;

  localparam logic [CFG_AW-1:0] CFG_BEAM_COUNT       = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_BLOCKS_PER_BEAM  = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_TOKENS_PER_BLOCK = 2'd2;

  localparam logic [BC_W-1:0]  BEAM_COUNT_RST       = 4'd1;
  localparam logic [BPB_W-1:0] BLOCKS_PER_BEAM_RST  = 5'd16;
  localparam logic [TPB_W-1:0] TOKENS_PER_BLOCK_RST = 16'd16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_ERR
  } state_e;

  typedef struct packed {
    logic             write;
    logic             start;
    logic             issue;
    logic             issue_err;
    logic [CNT_W-1:0] col;
    logic             last;
  } cmd_t;

  typedef struct packed {
    logic adv;
    logic bad;
    logic last_col;
    logic build;
  } sts_t;

endpackage

[hw/rtl/beam_block_copy_pair_builder.sv]
// ----------------------------------------------------------------------------
// beam_block_copy_pair_builder
// keeps one request's block table and emits per-column copy pairs for a beam
// ----------------------------------------------------------------------------
// A write transaction stores one table entry when its beam and column are
// in range. A build transaction emits one result per table column in use,
// one per cycle while the output is drained, and no new input is taken
// until its column walk has issued the last column. The column count in
// use is blocks_per_beam saturated to MAX_COLUMNS, with zero counting as
// one. Each step of the column walk does one table read of the parent row
// and one of the beam row; the walk holds while the output is stalled. A
// build with an out-of-range parent or beam gives a single error result.
// The table has no reset; entries must be written before a build reads
// them.
// ----------------------------------------------------------------------------
module beam_block_copy_pair_builder #(
  parameter int MAX_BEAMS   = 8,
  parameter int MAX_COLUMNS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bbcp_pkg::CFG_AW-1:0]   cfg_addr_i,
  input  logic [bbcp_pkg::CFG_DW-1:0]   cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // beam_index, column_index, block_id, parent, sequence_length, zero pad
  input  logic [bbcp_pkg::S_DATA_W-1:0] s_axis_tdata,
  // operation
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // source_block, destination_block, column_out, zero pad
  output logic [bbcp_pkg::M_DATA_W-1:0] m_axis_tdata,
  // status
  output logic                          m_axis_tuser,
  output logic                          m_axis_tlast
);

  `include "beam_block_copy_pair_builder_assert.svh"

  bbcp_pkg::cmd_t cmd;
  bbcp_pkg::sts_t sts;

  bbcp_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  bbcp_dp #(
    .MAX_BEAMS   (MAX_BEAMS),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_o   (m_axis_tdata),
    .m_tuser_o   (m_axis_tuser),
    .m_tlast_o   (m_axis_tlast)
  );

  `BBCP_ASSERT_IMP(a_err_is_last, m_axis_tvalid && m_axis_tuser,
    m_axis_tlast && (m_axis_tdata[bbcp_pkg::ID_W-1:0] == bbcp_pkg::NO_BLOCK),
    "error result must be a single last result with no copy")
  `BBCP_ASSERT_IMP(a_pair_consistent,
    m_axis_tvalid && m_axis_tdata[bbcp_pkg::M_SRC_LSB + bbcp_pkg::ID_W - 1],
    m_axis_tdata[bbcp_pkg::M_DST_LSB + bbcp_pkg::ID_W - 1],
    "source without copy must pair with destination without copy")
  `BBCP_ASSERT_IMP(a_issue_busy, cmd.issue || cmd.issue_err,
    sts.adv && !s_axis_tready,
    "column issued while read stage blocked or input open")
  `BBCP_ASSERT_NEXT(a_build_blocks_input,
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == bbcp_pkg::OP_BUILD),
    !s_axis_tready,
    "input reopened right after a build transaction")

endmodule

[hw/rtl/bbcp_ctrl.sv]
// ----------------------------------------------------------------------------
// bbcp_ctrl
// sequencer: takes input transactions and walks the columns of a build
// ----------------------------------------------------------------------------
module bbcp_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_valid_i,
  output logic          s_ready_o,
  input  bbcp_pkg::sts_t sts_i,
  output bbcp_pkg::cmd_t cmd_o
);

  bbcp_pkg::state_e state_q, state_d;
  logic [bbcp_pkg::CNT_W-1:0] col_q, col_d;
  logic accept;

  assign accept = s_valid_i && (state_q == bbcp_pkg::ST_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      bbcp_pkg::ST_IDLE: begin
        if (accept && sts_i.build) begin
          state_d = sts_i.bad ? bbcp_pkg::ST_ERR : bbcp_pkg::ST_RUN;
        end
      end
      bbcp_pkg::ST_RUN: begin
        if (sts_i.adv && sts_i.last_col) begin
          state_d = bbcp_pkg::ST_IDLE;
        end
      end
      bbcp_pkg::ST_ERR: begin
        if (sts_i.adv) begin
          state_d = bbcp_pkg::ST_IDLE;
        end
      end
      default: state_d = bbcp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_ready_o       = 1'b0;
    cmd_o.write     = 1'b0;
    cmd_o.start     = 1'b0;
    cmd_o.issue     = 1'b0;
    cmd_o.issue_err = 1'b0;
    cmd_o.col       = col_q;
    cmd_o.last      = sts_i.last_col;
    col_d           = col_q;
    case (state_q)
      bbcp_pkg::ST_IDLE: begin
        s_ready_o   = 1'b1;
        cmd_o.write = accept && !sts_i.build;
        cmd_o.start = accept && sts_i.build && !sts_i.bad;
        if (cmd_o.start) begin
          col_d = '0;
        end
      end
      bbcp_pkg::ST_RUN: begin
        cmd_o.issue = sts_i.adv;
        if (sts_i.adv) begin
          col_d = col_q + 1'b1;
        end
      end
      bbcp_pkg::ST_ERR: begin
        cmd_o.issue_err = sts_i.adv;
        cmd_o.last      = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bbcp_pkg::ST_IDLE;
      col_q   <= '0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
    end
  end

endmodule

[hw/rtl/bbcp_dp.sv]
// ----------------------------------------------------------------------------
// bbcp_dp
// datapath: config registers, block table, column read stage, output register
// ----------------------------------------------------------------------------
module bbcp_dp #(
  parameter int MAX_BEAMS   = 8,
  parameter int MAX_COLUMNS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bbcp_pkg::CFG_AW-1:0]   cfg_addr_i,
  input  logic [bbcp_pkg::CFG_DW-1:0]   cfg_wdata_i,
  input  logic [bbcp_pkg::S_DATA_W-1:0] s_tdata_i,
  input  logic                          s_tuser_i,
  input  bbcp_pkg::cmd_t                cmd_i,
  output bbcp_pkg::sts_t                sts_o,
  output logic                          m_tvalid_o,
  input  logic                          m_tready_i,
  output logic [bbcp_pkg::M_DATA_W-1:0] m_tdata_o,
  output logic                          m_tuser_o,
  output logic                          m_tlast_o
);

  localparam int DEPTH = MAX_BEAMS * MAX_COLUMNS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [bbcp_pkg::BC_W-1:0]  bc_q;
  logic [bbcp_pkg::BPB_W-1:0] bpb_q;
  logic [bbcp_pkg::TPB_W-1:0] tpb_q;
  logic [bbcp_pkg::BC_W-1:0]  nb;
  logic [bbcp_pkg::BPB_W-1:0] nc;
  logic [bbcp_pkg::TPB_W-1:0] tpb_eff;

  logic [bbcp_pkg::BEAM_W-1:0] beam_in;
  logic [bbcp_pkg::COL_W-1:0]  col_in;
  logic [bbcp_pkg::ID_W-1:0]   id_in;
  logic [bbcp_pkg::PAR_W-1:0]  par_in;
  logic [bbcp_pkg::LEN_W-1:0]  len_in;
  logic                        write_ok;

  logic [bbcp_pkg::BEAM_W-1:0] beam_q;
  logic [bbcp_pkg::BC_W-1:0]   par_q;
  logic [bbcp_pkg::LEN_W-1:0]  len_q;
  logic [bbcp_pkg::ACC_W-1:0]  acc_q, acc_d;

  logic [bbcp_pkg::ID_W-1:0] mem [DEPTH];
  logic [AW-1:0]             wr_addr, rd_p_addr, rd_b_addr;
  logic [bbcp_pkg::ID_W-1:0] src_rd_q, dst_rd_q;

  logic                       rd_vld_q, rd_vld_d;
  logic [bbcp_pkg::COL_W-1:0] rd_col_q;
  logic                       rd_act_q, rd_last_q, rd_err_q;
  logic                       adv, out_load, copy;

  logic                       out_vld_q;
  logic [bbcp_pkg::ID_W-1:0]  out_src_q, out_dst_q;
  logic [bbcp_pkg::COL_W-1:0] out_col_q;
  logic                       out_stat_q, out_last_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bc_q  <= bbcp_pkg::BEAM_COUNT_RST;
      bpb_q <= bbcp_pkg::BLOCKS_PER_BEAM_RST;
      tpb_q <= bbcp_pkg::TOKENS_PER_BLOCK_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        bbcp_pkg::CFG_BEAM_COUNT:       bc_q  <= cfg_wdata_i[bbcp_pkg::BC_W-1:0];
        bbcp_pkg::CFG_BLOCKS_PER_BEAM:  bpb_q <= cfg_wdata_i[bbcp_pkg::BPB_W-1:0];
        bbcp_pkg::CFG_TOKENS_PER_BLOCK: tpb_q <= cfg_wdata_i[bbcp_pkg::TPB_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (bc_q == '0) begin
      nb = bbcp_pkg::BC_W'(1);
    end else if (int'(bc_q) > MAX_BEAMS) begin
      nb = bbcp_pkg::BC_W'(MAX_BEAMS);
    end else begin
      nb = bc_q;
    end
    if (bpb_q == '0) begin
      nc = bbcp_pkg::BPB_W'(1);
    end else if (int'(bpb_q) > MAX_COLUMNS) begin
      nc = bbcp_pkg::BPB_W'(MAX_COLUMNS);
    end else begin
      nc = bpb_q;
    end
    tpb_eff = (tpb_q == '0) ? bbcp_pkg::TPB_W'(1) : tpb_q;
  end

  // input fields
  assign beam_in = s_tdata_i[bbcp_pkg::S_BEAM_LSB +: bbcp_pkg::BEAM_W];
  assign col_in  = s_tdata_i[bbcp_pkg::S_COL_LSB  +: bbcp_pkg::COL_W];
  assign id_in   = s_tdata_i[bbcp_pkg::S_ID_LSB   +: bbcp_pkg::ID_W];
  assign par_in  = s_tdata_i[bbcp_pkg::S_PAR_LSB  +: bbcp_pkg::PAR_W];
  assign len_in  = s_tdata_i[bbcp_pkg::S_LEN_LSB  +: bbcp_pkg::LEN_W];

  assign write_ok = (bbcp_pkg::BC_W'(beam_in) < nb) && (bbcp_pkg::BPB_W'(col_in) < nc);

  assign sts_o.build    = (s_tuser_i == bbcp_pkg::OP_BUILD);
  assign sts_o.bad      = par_in[bbcp_pkg::PAR_W-1]
                       || (par_in[bbcp_pkg::PAR_W-2:0] >= (bbcp_pkg::PAR_W-1)'(nb))
                       || (bbcp_pkg::BC_W'(beam_in) >= nb);
  assign sts_o.last_col = (cmd_i.col == (nc - 1'b1));

  // build context
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      beam_q <= beam_in;
      par_q  <= par_in[bbcp_pkg::BC_W-1:0];
      len_q  <= len_in;
    end
  end

  always_comb begin
    acc_d = acc_q;
    if (cmd_i.start) begin
      acc_d = '0;
    end else if (cmd_i.issue) begin
      acc_d = acc_q + bbcp_pkg::ACC_W'(tpb_eff);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  // block table
  assign wr_addr   = AW'(int'(beam_in) * MAX_COLUMNS + int'(col_in));
  assign rd_p_addr = AW'(int'(par_q) * MAX_COLUMNS + int'(cmd_i.col));
  assign rd_b_addr = AW'(int'(beam_q) * MAX_COLUMNS + int'(cmd_i.col));

  always_ff @(posedge clk_i) begin
    if (cmd_i.write && write_ok) begin
      mem[wr_addr] <= id_in;
    end
    if (cmd_i.issue) begin
      src_rd_q <= mem[rd_p_addr];
      dst_rd_q <= mem[rd_b_addr];
    end
  end

  // read stage
  assign out_load = rd_vld_q && (!out_vld_q || m_tready_i);
  assign adv      = !rd_vld_q || out_load;
  assign sts_o.adv = adv;

  always_comb begin
    rd_vld_d = rd_vld_q;
    if (adv) begin
      rd_vld_d = cmd_i.issue || cmd_i.issue_err;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= rd_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue || cmd_i.issue_err) begin
      rd_col_q  <= cmd_i.col[bbcp_pkg::COL_W-1:0];
      rd_act_q  <= (bbcp_pkg::BC_W'(beam_q) != par_q)
                && (bbcp_pkg::ACC_W'(len_q) > acc_q);
      rd_last_q <= cmd_i.last;
      rd_err_q  <= cmd_i.issue_err;
    end
  end

  // output register
  assign copy = rd_act_q && !src_rd_q[bbcp_pkg::ID_W-1] && !dst_rd_q[bbcp_pkg::ID_W-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (m_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_src_q  <= (copy && !rd_err_q) ? src_rd_q : bbcp_pkg::NO_BLOCK;
      out_dst_q  <= (copy && !rd_err_q) ? dst_rd_q : bbcp_pkg::NO_BLOCK;
      out_col_q  <= rd_err_q ? '0 : rd_col_q;
      out_stat_q <= rd_err_q ? bbcp_pkg::STAT_BAD_BEAM : bbcp_pkg::STAT_OK;
      out_last_q <= rd_last_q;
    end
  end

  assign m_tvalid_o = out_vld_q;
  assign m_tdata_o  = {{(bbcp_pkg::M_DATA_W - bbcp_pkg::M_COL_LSB - bbcp_pkg::COL_W){1'b0}},
                       out_col_q, out_dst_q, out_src_q};
  assign m_tuser_o  = out_stat_q;
  assign m_tlast_o  = out_last_q;

endmodule

[sim/beam_block_copy_pair_builder_tb.sv]
// ----------------------------------------------------------------------------
// beam_block_copy_pair_builder_tb
// fills four table rows, then runs directed and random write and build
// transactions under several register settings and idle patterns; every
// output pair is checked field by field against a local prediction
// ----------------------------------------------------------------------------
module beam_block_copy_pair_builder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_BEAMS    = 8;
  localparam int TABLE_COLS     = 16;
  localparam int FILL_BEAMS     = 4;
  localparam int SETTLE_CYCLES  = 24;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int S_PAD_W        = bbcp_pkg::S_DATA_W - bbcp_pkg::S_LEN_LSB - bbcp_pkg::LEN_W;

  typedef struct {
    logic                              op;
    logic [bbcp_pkg::BEAM_W-1:0]       beam;
    logic [bbcp_pkg::COL_W-1:0]        col;
    logic signed [bbcp_pkg::ID_W-1:0]  id;
    logic signed [bbcp_pkg::PAR_W-1:0] parent;
    logic [bbcp_pkg::LEN_W-1:0]        len;
  } copy_req_t;

  typedef struct {
    logic [bbcp_pkg::ID_W-1:0]  src;
    logic [bbcp_pkg::ID_W-1:0]  dst;
    logic [bbcp_pkg::COL_W-1:0] col;
    logic                       status;
    logic                       last;
  } copy_pair_t;

  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic                          cfg_we_i      = 1'b0;
  logic [bbcp_pkg::CFG_AW-1:0]   cfg_addr_i    = '0;
  logic [bbcp_pkg::CFG_DW-1:0]   cfg_wdata_i   = '0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [bbcp_pkg::S_DATA_W-1:0] s_axis_tdata  = '0;
  logic                          s_axis_tuser  = 1'b0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [bbcp_pkg::M_DATA_W-1:0] m_axis_tdata;
  logic                          m_axis_tuser;
  logic                          m_axis_tlast;

  logic [bbcp_pkg::BC_W-1:0]  beam_count_q      = bbcp_pkg::BEAM_COUNT_RST;
  logic [bbcp_pkg::BPB_W-1:0] blocks_per_beam_q = bbcp_pkg::BLOCKS_PER_BEAM_RST;
  logic [bbcp_pkg::TPB_W-1:0] tokens_per_blk_q  = bbcp_pkg::TOKENS_PER_BLOCK_RST;
  logic [bbcp_pkg::ID_W-1:0]  model_table [TABLE_BEAMS][TABLE_COLS];

  copy_req_t  pending_reqs[$];
  copy_pair_t expected_pairs[$];
  copy_req_t  drv_req;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         fail_count = 0;
  int         quiet_cycles = 0;

  beam_block_copy_pair_builder #(
    .MAX_BEAMS   (TABLE_BEAMS),
    .MAX_COLUMNS (TABLE_COLS)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #6 clk_i = ~clk_i;

  function automatic int eff_beams();
    if (int'(beam_count_q) == 0) return 1;
    if (int'(beam_count_q) > TABLE_BEAMS) return TABLE_BEAMS;
    return int'(beam_count_q);
  endfunction

  function automatic int eff_cols();
    if (int'(blocks_per_beam_q) == 0) return 1;
    if (int'(blocks_per_beam_q) > TABLE_COLS) return TABLE_COLS;
    return int'(blocks_per_beam_q);
  endfunction

  function automatic int eff_tokens();
    return (tokens_per_blk_q == '0) ? 1 : int'(tokens_per_blk_q);
  endfunction

  function automatic void predict_copy_pairs(copy_req_t r);
    int         nb;
    int         nc;
    int         p;
    int         used;
    copy_pair_t e;
    nb = eff_beams();
    nc = eff_cols();
    p  = int'(r.parent);
    if (r.op == bbcp_pkg::OP_WRITE) begin
      if (int'(r.beam) < nb && int'(r.col) < nc) model_table[r.beam][r.col] = r.id;
      return;
    end
    if (p < 0 || p >= nb || int'(r.beam) >= nb) begin
      e.src    = bbcp_pkg::NO_BLOCK;
      e.dst    = bbcp_pkg::NO_BLOCK;
      e.col    = '0;
      e.status = bbcp_pkg::STAT_BAD_BEAM;
      e.last   = 1'b1;
      expected_pairs.push_back(e);
      return;
    end
    used = (int'(r.len) + eff_tokens() - 1) / eff_tokens();
    for (int c = 0; c < nc; c++) begin
      e.src    = bbcp_pkg::NO_BLOCK;
      e.dst    = bbcp_pkg::NO_BLOCK;
      e.col    = c[bbcp_pkg::COL_W-1:0];
      e.status = bbcp_pkg::STAT_OK;
      e.last   = (c == nc - 1);
      if (p != int'(r.beam) && c < used) begin
        e.src = model_table[p][c];
        e.dst = model_table[r.beam][c];
        if (e.src[bbcp_pkg::ID_W-1] || e.dst[bbcp_pkg::ID_W-1]) begin
          e.src = bbcp_pkg::NO_BLOCK;
          e.dst = bbcp_pkg::NO_BLOCK;
        end
      end
      expected_pairs.push_back(e);
    end
  endfunction

  function automatic copy_req_t make_req(logic op, int beam, int col, int id,
                                         int parent, int len);
    copy_req_t r;
    r.op     = op;
    r.beam   = beam[bbcp_pkg::BEAM_W-1:0];
    r.col    = col[bbcp_pkg::COL_W-1:0];
    r.id     = id[bbcp_pkg::ID_W-1:0];
    r.parent = parent[bbcp_pkg::PAR_W-1:0];
    r.len    = len[bbcp_pkg::LEN_W-1:0];
    return r;
  endfunction

  function automatic copy_req_t random_req();
    copy_req_t   r;
    int          nb;
    int          nc;
    int          nf;
    int unsigned span;
    nb = eff_beams();
    nc = eff_cols();
    nf = (nb < FILL_BEAMS) ? nb : FILL_BEAMS;
    r = make_req(($urandom_range(99) < 50) ? bbcp_pkg::OP_BUILD : bbcp_pkg::OP_WRITE,
                 $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
    if ($urandom_range(99) < 80) begin
      r.beam = bbcp_pkg::BEAM_W'($urandom_range(0, nf - 1));
      if (r.op == bbcp_pkg::OP_WRITE) begin
        r.col = bbcp_pkg::COL_W'($urandom_range(0, nc - 1));
      end else begin
        r.parent = ($urandom_range(99) < 15) ? bbcp_pkg::PAR_W'(r.beam)
                                             : bbcp_pkg::PAR_W'($urandom_range(0, nf - 1));
        span = eff_tokens() * (nc + 1);
        if (span > 20'hFFFFF) span = 20'hFFFFF;
        r.len = bbcp_pkg::LEN_W'($urandom_range(0, span));
      end
    end else if (r.op == bbcp_pkg::OP_BUILD && !r.parent[bbcp_pkg::PAR_W-1]
                 && int'(r.parent) < nb && int'(r.beam) < nb
                 && (int'(r.beam) >= FILL_BEAMS || int'(r.parent) >= FILL_BEAMS)) begin
      // keep builds off rows that were never filled
      r.parent = bbcp_pkg::PAR_W'(nb);
    end
    case ($urandom_range(9))
      0, 1:    r.id = bbcp_pkg::NO_BLOCK;
      2:       ;
      default: r.id = bbcp_pkg::ID_W'($urandom_range(0, 65535));
    endcase
    return r;
  endfunction

  task automatic write_reg(input logic [bbcp_pkg::CFG_AW-1:0] addr, input int value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= value[bbcp_pkg::CFG_DW-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (addr)
      bbcp_pkg::CFG_BEAM_COUNT:       beam_count_q      = value[bbcp_pkg::BC_W-1:0];
      bbcp_pkg::CFG_BLOCKS_PER_BEAM:  blocks_per_beam_q = value[bbcp_pkg::BPB_W-1:0];
      bbcp_pkg::CFG_TOKENS_PER_BLOCK: tokens_per_blk_q  = value[bbcp_pkg::TPB_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input int beams, input int cols, input int tokens);
    write_reg(bbcp_pkg::CFG_BEAM_COUNT, beams);
    write_reg(bbcp_pkg::CFG_BLOCKS_PER_BEAM, cols);
    write_reg(bbcp_pkg::CFG_TOKENS_PER_BLOCK, tokens);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || s_axis_tvalid || expected_pairs.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic run_random(input int beams, input int cols, input int tokens,
                            input int send_pct, input int recv_pct, input int count);
    set_config(beams, cols, tokens);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    repeat (count) pending_reqs.push_back(random_req());
    wait_drained();
  endtask

  task automatic check_field(input string name, input int exp_val, input int got_val);
    if (exp_val != got_val) begin
      $error("%s expected %0d actual %0d", name, exp_val, got_val);
      fail_count++;
    end
  endtask

  // stimulus driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) predict_copy_pairs(drv_req);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          drv_req = pending_reqs.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= drv_req.op;
          s_axis_tdata  <= {{S_PAD_W{1'b0}}, drv_req.len, drv_req.parent, drv_req.id,
                            drv_req.col, drv_req.beam};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // result monitor
  always @(posedge clk_i) begin : monitor
    copy_pair_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_pairs.size() == 0) begin
        $error("unexpected result, source_block %0d column_out %0d",
               $signed(m_axis_tdata[bbcp_pkg::M_SRC_LSB +: bbcp_pkg::ID_W]),
               m_axis_tdata[bbcp_pkg::M_COL_LSB +: bbcp_pkg::COL_W]);
        fail_count++;
      end else begin
        e = expected_pairs.pop_front();
        check_field("source_block", int'($signed(e.src)),
                    int'($signed(m_axis_tdata[bbcp_pkg::M_SRC_LSB +: bbcp_pkg::ID_W])));
        check_field("destination_block", int'($signed(e.dst)),
                    int'($signed(m_axis_tdata[bbcp_pkg::M_DST_LSB +: bbcp_pkg::ID_W])));
        check_field("column_out", int'(e.col),
                    int'(m_axis_tdata[bbcp_pkg::M_COL_LSB +: bbcp_pkg::COL_W]));
        check_field("status", int'(e.status), int'(m_axis_tuser));
        check_field("last", int'(e.last), int'(m_axis_tlast));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("beam_block_copy_pair_builder_tb failed");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // write every entry of the filled rows once so no result uses an unwritten one
    set_config(TABLE_BEAMS, TABLE_COLS, 16);
    for (int b = 0; b < FILL_BEAMS; b++) begin
      for (int c = 0; c < TABLE_COLS; c++) begin
        pending_reqs.push_back(make_req(bbcp_pkg::OP_WRITE, b, c,
          ($urandom_range(99) < 20) ? -1 : int'($urandom_range(0, 65535)), 0, 0));
      end
    end

    pending_reqs.push_back(make_req(bbcp_pkg::OP_WRITE, 0, 0, 65535, 0, 0));
    pending_reqs.push_back(make_req(bbcp_pkg::OP_WRITE, 7, 15, -65536, 255, 20'hFFFFF));
    pending_reqs.push_back(make_req(bbcp_pkg::OP_WRITE, 1, 0, -1, 0, 0));
    pending_reqs.push_back(make_req(bbcp_pkg::OP_WRITE, 1, 1, 0, 0, 0));
    pending_reqs.push_back(make_req(bbcp_pkg::OP_WRITE, 0, 1, 12345, 0, 0));
    pending_reqs.push_back(make_req(bbcp_pkg::OP_WRITE, 7, 0, 4242, 0, 0));
    pending_reqs.push_back(make_req(bbcp_pkg::OP_BUILD, 1, 0, 0, 0, 20'hFFFFF));
    pending_reqs.push_back(make_req(bbcp_pkg::OP_BUILD, 1, 15, -1, 0, 0));
    pending_reqs.push_back(make_req(bbcp_pkg::OP_BUILD, 1, 0, 0, 0, 17));
    pending_reqs.push_back(make_req(bbcp_pkg::OP_BUILD, 1, 0, 0, 0, 16));
    pending_reqs.push_back(make_req(bbcp_pkg::OP_BUILD, 3, 0, 0, 3, 1000));
    pending_reqs.push_back(make_req(bbcp_pkg::OP_BUILD, 7, 0, 0, -1, 100));
    pending_reqs.push_back(make_req(bbcp_pkg::OP_BUILD, 0, 0, 0, 255, 100));
    pending_reqs.push_back(make_req(bbcp_pkg::OP_BUILD, 0, 0, 0, -256, 100));
    pending_reqs.push_back(make_req(bbcp_pkg::OP_BUILD, 7, 0, 0, 0, 16));
    pending_reqs.push_back(make_req(bbcp_pkg::OP_BUILD, 0, 0, 0, 7, 16));
    pending_reqs.push_back(make_req(bbcp_pkg::OP_BUILD, 2, 0, 0, 3, 1));
    wait_drained();

    set_config(3, 5, 7);
    pending_reqs.push_back(make_req(bbcp_pkg::OP_WRITE, 5, 0, 77, 0, 0));
    pending_reqs.push_back(make_req(bbcp_pkg::OP_WRITE, 0, 7, 77, 0, 0));
    pending_reqs.push_back(make_req(bbcp_pkg::OP_BUILD, 4, 0, 0, 0, 35));
    pending_reqs.push_back(make_req(bbcp_pkg::OP_BUILD, 0, 0, 0, 3, 35));
    pending_reqs.push_back(make_req(bbcp_pkg::OP_BUILD, 0, 0, 0, 2, 35));
    wait_drained();

    run_random(TABLE_BEAMS, TABLE_COLS, 16, 0, 0, 5);
    run_random(0, 0, 0, 72, 0, 5);
    run_random(15, 31, 65535, 0, 72, 5);
    run_random(3, 5, 7, 32, 32, 5);
    run_random(TABLE_BEAMS, TABLE_COLS, 1, 0, 0, 4);
    run_random(5, 11, 300, 32, 32, 4);

    if (fail_count == 0) begin
      $display("beam_block_copy_pair_builder_tb passed");
    end else begin
      $display("beam_block_copy_pair_builder_tb failed");
    end
    $finish;
  end

endmodule
